FILE: hdl/fls_pkg.sv
package fls_pkg;

  localparam int SYM_W       = 8;
  localparam int SYM_VALUES  = 256;
  localparam int MAX_SYMBOLS = 256;
  localparam int CNT_W       = 9;
  localparam int LEN_W       = 4;
  localparam int CMD_W       = 2;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(SYM_W);

  localparam logic [CMD_W-1:0] CMD_LEARN  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DECODE = 2'd2;

  localparam logic KIND_CODE   = 1'b0;
  localparam logic KIND_SYMBOL = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LRN   = 7'b0000010,
    S_LEN   = 7'b0000100,
    S_ENC   = 7'b0001000,
    S_EWAIT = 7'b0010000,
    S_DCHK  = 7'b0100000,
    S_DRD   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic             wr;
    logic             map_rd;
    logic             store_rd;
    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] idx;
  } dict_req_t;

endpackage

FILE: hdl/fls_dict.sv
module fls_dict (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fls_pkg::dict_req_t        req,
  output logic                      map_valid,
  output logic [fls_pkg::SYM_W-1:0] map_rdata,
  output logic [fls_pkg::SYM_W-1:0] store_rdata
);

  logic [fls_pkg::SYM_VALUES-1:0] valid_r;
  logic [fls_pkg::SYM_W-1:0]      map_mem [fls_pkg::SYM_VALUES];
  logic [fls_pkg::SYM_W-1:0]      store_mem [fls_pkg::MAX_SYMBOLS];
  logic [fls_pkg::SYM_W-1:0]      map_rdata_r;
  logic [fls_pkg::SYM_W-1:0]      store_rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr) begin
      valid_r[req.sym] <= 1'b1;
    end
  end

  // index map: symbol -> index
  always_ff @(posedge clk) begin
    if (req.wr) begin
      map_mem[req.sym] <= req.idx;
    end
    if (req.map_rd) begin
      map_rdata_r <= map_mem[req.sym];
    end
  end

  // symbol store: index -> symbol
  always_ff @(posedge clk) begin
    if (req.wr) begin
      store_mem[req.idx] <= req.sym;
    end
    if (req.store_rd) begin
      store_rdata_r <= store_mem[req.idx];
    end
  end

  assign map_valid   = valid_r[req.sym];
  assign map_rdata   = map_rdata_r;
  assign store_rdata = store_rdata_r;

endmodule

FILE: hdl/fls_ctrl.sv
module fls_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [fls_pkg::CMD_W-1:0] in_command,
  input  logic [fls_pkg::SYM_W-1:0] in_symbol,
  input  logic                      in_code_bit,
  output fls_pkg::dict_req_t        req,
  input  logic                      map_valid,
  input  logic [fls_pkg::SYM_W-1:0] map_rdata,
  input  logic [fls_pkg::SYM_W-1:0] store_rdata,
  output logic                      out_strobe,
  output logic                      out_result_kind,
  output logic [fls_pkg::SYM_W-1:0] out_code_word,
  output logic [fls_pkg::LEN_W-1:0] out_code_length,
  output logic [fls_pkg::SYM_W-1:0] out_decoded_symbol
);

  fls_pkg::state_t state_r, state_nxt;

  logic [fls_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [fls_pkg::SYM_W-1:0] sym_r, sym_nxt;
  logic                      bit_r, bit_nxt;
  logic [fls_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [fls_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [fls_pkg::SYM_W-1:0] acc_r, acc_nxt;
  logic [fls_pkg::LEN_W-1:0] held_r, held_nxt;
  logic [fls_pkg::SYM_W-1:0] idx_r, idx_nxt;

  logic                      strobe_r, strobe_nxt;
  logic                      kind_r, kind_nxt;
  logic [fls_pkg::SYM_W-1:0] word_r, word_nxt;
  logic [fls_pkg::LEN_W-1:0] olen_r, olen_nxt;
  logic [fls_pkg::SYM_W-1:0] dsym_r, dsym_nxt;

  logic [fls_pkg::CNT_W-1:0] cmp_a, cmp_b;
  logic                      cmp_lt;
  logic [fls_pkg::SYM_W-1:0] acc_shift;
  logic [fls_pkg::LEN_W-1:0] held_inc;

  // shared compare unit
  always_comb begin
    case (state_r)
      fls_pkg::S_LEN: begin
        cmp_a = fls_pkg::CNT_W'(1) << len_r;
        cmp_b = count_r;
      end
      fls_pkg::S_LRN: begin
        cmp_a = count_r;
        cmp_b = fls_pkg::CNT_W'(fls_pkg::MAX_SYMBOLS);
      end
      fls_pkg::S_DCHK: begin
        cmp_a = fls_pkg::CNT_W'(idx_r);
        cmp_b = count_r;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  assign cmp_lt    = cmp_a < cmp_b;
  assign acc_shift = {acc_r[fls_pkg::SYM_W-2:0], bit_r};
  assign held_inc  = held_r + fls_pkg::LEN_W'(1);

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    sym_nxt      = sym_r;
    bit_nxt      = bit_r;
    len_nxt      = len_r;
    count_nxt    = count_r;
    acc_nxt      = acc_r;
    held_nxt     = held_r;
    idx_nxt      = idx_r;
    strobe_nxt   = 1'b0;
    kind_nxt     = kind_r;
    word_nxt     = word_r;
    olen_nxt     = olen_r;
    dsym_nxt     = dsym_r;
    req          = '0;
    req.sym      = sym_r;
    req.idx      = idx_r;
    case (state_r)
      fls_pkg::S_IDLE: begin
        if (start) begin
          cmd_nxt = in_command;
          sym_nxt = in_symbol;
          bit_nxt = in_code_bit;
          len_nxt = fls_pkg::LEN_W'(1);
          case (in_command)
            fls_pkg::CMD_LEARN:  state_nxt = fls_pkg::S_LRN;
            fls_pkg::CMD_ENCODE: state_nxt = fls_pkg::S_LEN;
            fls_pkg::CMD_DECODE: state_nxt = fls_pkg::S_LEN;
            default:             state_nxt = fls_pkg::S_IDLE;
          endcase
        end
      end
      fls_pkg::S_LRN: begin
        req.idx = count_r[fls_pkg::SYM_W-1:0];
        if (!map_valid && cmp_lt) begin
          req.wr    = 1'b1;
          count_nxt = count_r + fls_pkg::CNT_W'(1);
        end
        state_nxt = fls_pkg::S_IDLE;
      end
      fls_pkg::S_LEN: begin
        if (len_r < fls_pkg::LEN_MAX && cmp_lt) begin
          len_nxt = len_r + fls_pkg::LEN_W'(1);
        end else if (cmd_r == fls_pkg::CMD_ENCODE) begin
          state_nxt = fls_pkg::S_ENC;
        end else if (held_inc >= len_r) begin
          acc_nxt   = '0;
          held_nxt  = '0;
          idx_nxt   = acc_shift;
          state_nxt = fls_pkg::S_DCHK;
        end else begin
          acc_nxt   = acc_shift;
          held_nxt  = held_inc;
          state_nxt = fls_pkg::S_IDLE;
        end
      end
      fls_pkg::S_ENC: begin
        if (map_valid) begin
          req.map_rd = 1'b1;
          state_nxt  = fls_pkg::S_EWAIT;
        end else begin
          state_nxt = fls_pkg::S_IDLE;
        end
      end
      fls_pkg::S_EWAIT: begin
        strobe_nxt = 1'b1;
        kind_nxt   = fls_pkg::KIND_CODE;
        word_nxt   = map_rdata;
        olen_nxt   = len_r;
        dsym_nxt   = '0;
        state_nxt  = fls_pkg::S_IDLE;
      end
      fls_pkg::S_DCHK: begin
        if (cmp_lt) begin
          req.store_rd = 1'b1;
          state_nxt    = fls_pkg::S_DRD;
        end else begin
          state_nxt = fls_pkg::S_IDLE;
        end
      end
      fls_pkg::S_DRD: begin
        strobe_nxt = 1'b1;
        kind_nxt   = fls_pkg::KIND_SYMBOL;
        word_nxt   = idx_r;
        olen_nxt   = len_r;
        dsym_nxt   = store_rdata;
        state_nxt  = fls_pkg::S_IDLE;
      end
      default: begin
        state_nxt = fls_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fls_pkg::S_IDLE;
      count_r  <= '0;
      acc_r    <= '0;
      held_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      acc_r    <= acc_nxt;
      held_r   <= held_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    sym_r  <= sym_nxt;
    bit_r  <= bit_nxt;
    len_r  <= len_nxt;
    idx_r  <= idx_nxt;
    kind_r <= kind_nxt;
    word_r <= word_nxt;
    olen_r <= olen_nxt;
    dsym_r <= dsym_nxt;
  end

  assign busy               = (state_r != fls_pkg::S_IDLE);
  assign out_strobe         = strobe_r;
  assign out_result_kind    = kind_r;
  assign out_code_word      = word_r;
  assign out_code_length    = olen_r;
  assign out_decoded_symbol = dsym_r;

endmodule

FILE: hdl/fixed_length_symbol_codec_core.sv
// fixed-length dictionary codec for byte symbols
// input transaction: start high while busy is low; in_command selects
//   learn (add in_symbol to the dictionary), encode (look up in_symbol)
//   or decode (shift in in_code_bit, msb first)
// result transaction: out_strobe high for one cycle with out_result_kind,
//   out_code_word, out_code_length and out_decoded_symbol; at most one
//   result per input transaction, and the receiver cannot hold it off
// the code length is found by a shared comparator that steps the width
//   up one bit per cycle, so cost grows with the dictionary size (L bits)
// learn: no result is given
// encode: out_strobe rises as busy drops;
//   no result for an unknown symbol
// decode: a result only when a code word of L bits completes with a symbol,
//   none when the completed index lies beyond the dictionary
// unused command code: accepted and ignored, busy stays low
// dictionary lookups use one registered read of the index map or the
//   symbol store
// reset clears the dictionary, the bit accumulator, the state and the strobe;
//   the block is ready once reset is released
module fixed_length_symbol_codec_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [fls_pkg::CMD_W-1:0] in_command,
  input  logic [fls_pkg::SYM_W-1:0] in_symbol,
  input  logic                      in_code_bit,
  output logic                      out_strobe,
  output logic                      out_result_kind,
  output logic [fls_pkg::SYM_W-1:0] out_code_word,
  output logic [fls_pkg::LEN_W-1:0] out_code_length,
  output logic [fls_pkg::SYM_W-1:0] out_decoded_symbol
);

  fls_pkg::dict_req_t        req;
  logic                      map_valid;
  logic [fls_pkg::SYM_W-1:0] map_rdata;
  logic [fls_pkg::SYM_W-1:0] store_rdata;

  fls_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_symbol          (in_symbol),
    .in_code_bit        (in_code_bit),
    .req                (req),
    .map_valid          (map_valid),
    .map_rdata          (map_rdata),
    .store_rdata        (store_rdata),
    .out_strobe         (out_strobe),
    .out_result_kind    (out_result_kind),
    .out_code_word      (out_code_word),
    .out_code_length    (out_code_length),
    .out_decoded_symbol (out_decoded_symbol)
  );

  fls_dict u_dict (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .map_valid   (map_valid),
    .map_rdata   (map_rdata),
    .store_rdata (store_rdata)
  );

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_code_length >= fls_pkg::LEN_W'(1) &&
                    out_code_length <= fls_pkg::LEN_MAX))
    else $error("code length out of range");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back results");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == fls_pkg::CMD_LEARN ||
                        in_command == fls_pkg::CMD_ENCODE ||
                        in_command == fls_pkg::CMD_DECODE)) |=> busy)
    else $error("transaction accepted without going busy");

  a_encode_no_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result_kind == fls_pkg::KIND_CODE) |->
      out_decoded_symbol == '0)
    else $error("encode result carries a symbol");

endmodule
